/* hdl/bbcm_pkg.sv */
// Shared types and constants for the bounding box cluster merge block.
`timescale 1ns / 1ps
package bbcm_pkg;

  localparam int unsigned CmdW = 1;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegRelaxMargin = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLayerSelect = 1'b1;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned FieldW = 32;
  localparam int unsigned LayerW = 8;
  localparam int unsigned MarginW = 16;
  localparam int unsigned SelW = 9;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [FieldW-1:0] start_x;
    logic signed [FieldW-1:0] start_y;
    logic signed [FieldW-1:0] end_x;
    logic signed [FieldW-1:0] end_y;
    logic [LayerW-1:0]        layer;
  } seg_item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] box_min_x;
    logic signed [FieldW-1:0] box_min_y;
    logic signed [FieldW-1:0] box_max_x;
    logic signed [FieldW-1:0] box_max_y;
    logic                     last_box;
    logic                     no_boxes;
    logic                     table_overflow;
  } box_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

/* hdl/bbcm_seg_if.sv */
// Valid/ready channel interfaces for segment input, box output and config writes.
`timescale 1ns / 1ps
interface bbcm_seg_if import bbcm_pkg::*; ();
  logic      valid;
  logic      ready;
  seg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bbcm_box_if import bbcm_pkg::*; ();
  logic      valid;
  logic      ready;
  box_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bbcm_cfg_if import bbcm_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hdl/bbcm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bbcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/bounding_box_cluster_merge_core.sv */
// Top level: segment-to-box clustering over a box table held in RAM.
//
//  channel  | dir | handshake           | carries
//  seg_in   | in  | valid/ready         | command, endpoints, layer
//  box_out  | out | valid/ready         | one merged box per item, last/empty/overflow
//  cfg      | in  | valid/ready         | register index, write data
//
// Sequencing: an add reads and compares each table entry in turn; a merge copies the last
// entry into the matching slot, which is read again; the grown box is then appended, or
// the overflow flag set if the table is full. An add on an unselected layer is dropped.
// Finish: each pass takes every entry as pivot, merges later entries into it and writes
// it back; passes repeat until one merges nothing, then every box is read and emitted; an
// empty table gives its single item after the pass. Reset clears state, entry count,
// overflow flag and margin, sets layer select to all ones and leaves table RAM uncleared.
// A stalled output holds the box and the sequencer in emit; seg_in is ready only in idle,
// so the next item can be taken while the last box of a finish still waits.
`timescale 1ns / 1ps
module bounding_box_cluster_merge_core import bbcm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bbcm_seg_if.sink   seg_in,
  bbcm_box_if.source box_out,
  bbcm_cfg_if.sink   cfg
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CX = COORD_WIDTH;
  localparam int unsigned RW = 4 * CX;
  localparam logic signed [CX+1:0] CMax = (CX+2)'((64'sd1 <<< (CX - 1)) - 1);
  localparam logic signed [CX+1:0] CMin = -CMax - (CX+2)'(1);

  typedef enum logic [11:0] {
    StIdle     = 12'b000000000001,
    StScanRd   = 12'b000000000010, // issue read of entry j
    StScanCmp  = 12'b000000000100, // compare entry j with new box
    StScanMove = 12'b000000001000, // last entry read; write into slot j
    StAppend   = 12'b000000010000,
    StPairPiv  = 12'b000000100000, // issue read of pivot i
    StPairLd   = 12'b000001000000, // latch pivot
    StPairRd   = 12'b000010000000, // issue read of entry j, or write back pivot
    StPairCmp  = 12'b000100000000,
    StPairMove = 12'b001000000000,
    StEmitRd   = 12'b010000000000,
    StEmit     = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic signed [CX-1:0] x0;
    logic signed [CX-1:0] x1;
    logic signed [CX-1:0] y0;
    logic signed [CX-1:0] y1;
  } box_t;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] j_q, j_d, i_q, i_d;
  logic          ovf_q, ovf_d, merged_q, merged_d;
  box_t          cur_q, cur_d;
  logic [MarginW-1:0] margin_q;
  logic signed [SelW-1:0] sel_q;
  box_item_t     out_q, out_d;
  logic          out_v_q, out_v_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  box_t          wdata, rdata;

  bbcm_ram #(.Width(RW), .Depth(TABLE_DEPTH)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Saturate a full-width input to the coordinate range.
  function automatic logic signed [CX+1:0] sat(input logic signed [CX+1:0] v);
    logic signed [CX+1:0] r;
    r = v;
    if (v > CMax) r = CMax;
    if (v < CMin) r = CMin;
    return r;
  endfunction

  function automatic logic signed [CX+1:0] sat_in(input logic signed [FieldW-1:0] v);
    logic signed [FieldW+1:0] w;
    w = (FieldW+2)'(v);
    if (w > (FieldW+2)'(CMax)) w = (FieldW+2)'(CMax);
    if (w < (FieldW+2)'(CMin)) w = (FieldW+2)'(CMin);
    return (CX+2)'(w);
  endfunction

  // Closed intervals: touching edges count as overlap.
  function automatic logic ovl(input box_t a, input box_t b);
    return a.x0 <= b.x1 && b.x0 <= a.x1 && a.y0 <= b.y1 && b.y0 <= a.y1;
  endfunction

  function automatic box_t hull(input box_t a, input box_t b);
    box_t r;
    r.x0 = (b.x0 < a.x0) ? b.x0 : a.x0;
    r.x1 = (b.x1 > a.x1) ? b.x1 : a.x1;
    r.y0 = (b.y0 < a.y0) ? b.y0 : a.y0;
    r.y1 = (b.y1 > a.y1) ? b.y1 : a.y1;
    return r;
  endfunction

  // Segment box: endpoint hull grown by the margin, saturated.
  logic signed [CX+1:0] sx, sy, ex, ey, m;
  box_t seg_box;
  always_comb begin
    sx = sat_in(seg_in.item.start_x);
    sy = sat_in(seg_in.item.start_y);
    ex = sat_in(seg_in.item.end_x);
    ey = sat_in(seg_in.item.end_y);
    m  = (CX+2)'(margin_q);
    seg_box.x0 = CX'(sat(((sx < ex) ? sx : ex) - m));
    seg_box.x1 = CX'(sat(((sx > ex) ? sx : ex) + m));
    seg_box.y0 = CX'(sat(((sy < ey) ? sy : ey) - m));
    seg_box.y1 = CX'(sat(((sy > ey) ? sy : ey) + m));
  end

  // Negative select keeps every layer.
  logic layer_hit;
  assign layer_hit = sel_q[SelW-1] || (sel_q[LayerW-1:0] == seg_in.item.layer);

  assign seg_in.ready  = (state_q == StIdle);
  assign cfg.ready     = 1'b1;
  assign box_out.valid = out_v_q;
  assign box_out.item  = out_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    j_d      = j_q;
    i_d      = i_q;
    ovf_d    = ovf_q;
    merged_d = merged_q;
    cur_d    = cur_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !box_out.ready;
    we       = 1'b0;
    waddr    = AW'(j_q);
    wdata    = cur_q;
    raddr    = AW'(j_q);
    unique case (state_q)
      StIdle: begin
        if (seg_in.valid) begin
          j_d = '0;
          i_d = '0;
          merged_d = 1'b0;
          if (seg_in.item.command == CmdFinish) begin
            state_d = StPairPiv;
          end else if (layer_hit) begin
            cur_d = seg_box;
            state_d = StScanRd;
          end
        end
      end
      StScanRd: begin
        state_d = (j_q < count_q) ? StScanCmp : StAppend;
      end
      StScanCmp: begin
        if (ovl(rdata, cur_q)) begin
          cur_d = hull(cur_q, rdata);
          count_d = count_q - 1'b1;
          raddr = AW'(count_q - 1'b1);
          state_d = StScanMove;
        end else begin
          j_d = j_q + 1'b1;
          state_d = StScanRd;
        end
      end
      StScanMove: begin
        // rdata holds the last entry; copy it into slot j and rescan j
        we = 1'b1;
        wdata = rdata;
        state_d = StScanRd;
      end
      StAppend: begin
        if (count_q >= CW'(TABLE_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          we = 1'b1;
          waddr = AW'(count_q);
          wdata = cur_q;
          count_d = count_q + 1'b1;
        end
        state_d = StIdle;
      end
      StPairPiv: begin
        if (i_q >= count_q) begin
          if (merged_q) begin
            i_d = '0;
            merged_d = 1'b0;
          end else begin
            j_d = '0;
            state_d = StEmitRd;
          end
        end else begin
          raddr = AW'(i_q);
          j_d = i_q + 1'b1;
          state_d = StPairLd;
        end
      end
      StPairLd: begin
        cur_d = rdata;
        state_d = StPairRd;
      end
      StPairRd: begin
        if (j_q < count_q) begin
          state_d = StPairCmp;
        end else begin
          // pivot done: write the grown box back to slot i
          we = 1'b1;
          waddr = AW'(i_q);
          wdata = cur_q;
          i_d = i_q + 1'b1;
          state_d = StPairPiv;
        end
      end
      StPairCmp: begin
        if (ovl(rdata, cur_q)) begin
          cur_d = hull(cur_q, rdata);
          count_d = count_q - 1'b1;
          merged_d = 1'b1;
          raddr = AW'(count_q - 1'b1);
          state_d = StPairMove;
        end else begin
          j_d = j_q + 1'b1;
          state_d = StPairRd;
        end
      end
      StPairMove: begin
        we = 1'b1;
        wdata = rdata;
        state_d = StPairRd;
      end
      StEmitRd: begin
        if (count_q == '0) begin
          if (!out_v_q || box_out.ready) begin
            out_d = '0;
            out_d.last_box = 1'b1;
            out_d.no_boxes = 1'b1;
            out_d.table_overflow = ovf_q;
            out_v_d = 1'b1;
            ovf_d = 1'b0;
            state_d = StIdle;
          end
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // raddr stays at j, so rdata holds while the output stalls
        if (!out_v_q || box_out.ready) begin
          out_d.box_min_x = FieldW'(rdata.x0);
          out_d.box_min_y = FieldW'(rdata.y0);
          out_d.box_max_x = FieldW'(rdata.x1);
          out_d.box_max_y = FieldW'(rdata.y1);
          out_d.last_box = (j_q + 1'b1 == count_q);
          out_d.no_boxes = 1'b0;
          out_d.table_overflow = ovf_q;
          out_v_d = 1'b1;
          j_d = j_q + 1'b1;
          if (j_q + 1'b1 == count_q) begin
            count_d = '0;
            ovf_d = 1'b0;
            state_d = StIdle;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      j_q      <= '0;
      i_q      <= '0;
      ovf_q    <= 1'b0;
      merged_q <= 1'b0;
      cur_q    <= '0;
      out_q    <= '0;
      out_v_q  <= 1'b0;
      margin_q <= '0;
      sel_q    <= '1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      j_q      <= j_d;
      i_q      <= i_d;
      ovf_q    <= ovf_d;
      merged_q <= merged_d;
      cur_q    <= cur_d;
      out_q    <= out_d;
      out_v_q  <= out_v_d;
      if (cfg.valid && cfg.ready && cfg.item.index == RegRelaxMargin) begin
        margin_q <= cfg.item.data[MarginW-1:0];
      end
      if (cfg.valid && cfg.ready && cfg.item.index == RegLayerSelect) begin
        sel_q <= cfg.item.data[SelW-1:0];
      end
    end
  end
endmodule
